/* src/mta_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mta_pkg: shared definitions of the multi-test ALU step block
// Request and opcode codes, flag bit positions, parameter defaults.
// ----------------------------------------------------------------------------
package mta_pkg;

	localparam int DEF_NUM_REGS  = 8;
	localparam int DEF_MAX_TESTS = 8;

	localparam int DATA_W = 16;
	localparam int FLAG_W = 4;
	localparam int MASK_W = 8;
	localparam int CFG_AW = 3;

	localparam logic [CFG_AW-1:0] ADDR_TEST_COUNT = 3'd0;
	localparam logic [3:0]        TEST_COUNT_RST  = 4'd1;

	localparam logic [2:0] REQ_CLEAR = 3'd0;
	localparam logic [2:0] REQ_WRITE = 3'd1;
	localparam logic [2:0] REQ_EXPECT = 3'd2;
	localparam logic [2:0] REQ_EXEC = 3'd3;
	localparam logic [2:0] REQ_READ = 3'd4;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MUL  = 4'd2;
	localparam logic [3:0] OP_DIV  = 4'd3;
	localparam logic [3:0] OP_MOD  = 4'd4;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_OR   = 4'd6;
	localparam logic [3:0] OP_XOR  = 4'd7;
	localparam logic [3:0] OP_SHL  = 4'd8;
	localparam logic [3:0] OP_SHR  = 4'd9;
	localparam logic [3:0] OP_ASR  = 4'd10;
	localparam logic [3:0] OP_LDI  = 4'd11;
	localparam logic [3:0] OP_ADDI = 4'd12;

	localparam int FL_Z = 0;
	localparam int FL_N = 1;
	localparam int FL_C = 2;
	localparam int FL_V = 3;

endpackage

/* src/mta_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mta_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mta_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/multi_test_alu_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_test_alu_step: per-test register files with a shared ALU
// Clear, write, expect, execute and read items over up to MAX_TEST_CASES
// register files; every result carries the live/match summary.
// ----------------------------------------------------------------------------
// One item is in flight at a time; in_stall is high from the transfer of an
// item until its result is loaded into the output register. Every item ends
// with a match sweep over registers 1..NUM_REGS-1: a read (MRD) and a compare
// (MCMP) per (register, test) pair over the n tests in use
// (n = min(test_count, MAX_TEST_CASES)), or per register when no test is
// in use. An execute item adds, per test, a pass through the shared ALU
// (two register-file reads, operate, write back); div and mod first run a
// zero-divisor check (CHKR, CHKW) per test and then pass each test through
// the shared divider, one quotient bit per cycle. The single read port of
// the register-file RAM serialises these steps. A read item adds an RDW
// step. The last compare of the sweep waits while the output register still
// holds a result that has not been taken; once loaded, a result may sit in
// the output register while the next item is transferred in. Registers of
// never-written entries read as zero through per-entry valid bits, which a
// clear item drops all at once.
module multi_test_alu_step #(
	parameter int NUM_REGS       = mta_pkg::DEF_NUM_REGS,
	parameter int MAX_TEST_CASES = mta_pkg::DEF_MAX_TESTS
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [3:0]  opcode,
	input  logic [2:0]  dest_reg,
	input  logic [2:0]  src_a_reg,
	input  logic [2:0]  src_b_reg,
	input  logic [7:0]  immediate,
	input  logic [2:0]  test_index,
	input  logic [15:0] data_value,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [7:0]  match_mask,
	output logic [7:0]  live_mask,
	output logic [7:0]  depth_now,
	output logic [15:0] read_value,
	output logic [3:0]  read_flags
);

	localparam int TW    = (MAX_TEST_CASES > 1) ? $clog2(MAX_TEST_CASES) : 1;
	localparam int RW    = $clog2(NUM_REGS);
	localparam int NW    = $clog2(MAX_TEST_CASES + 1);
	localparam int DEPTH = MAX_TEST_CASES * NUM_REGS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW    = mta_pkg::DATA_W;
	localparam int FW    = mta_pkg::FLAG_W;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_CHKR = 12'b0000_0000_0010,
		ST_CHKW = 12'b0000_0000_0100,
		ST_ARD  = 12'b0000_0000_1000,
		ST_BRD  = 12'b0000_0001_0000,
		ST_EXEC = 12'b0000_0010_0000,
		ST_DIV  = 12'b0000_0100_0000,
		ST_DFIN = 12'b0000_1000_0000,
		ST_WR   = 12'b0001_0000_0000,
		ST_RDW  = 12'b0010_0000_0000,
		ST_MRD  = 12'b0100_0000_0000,
		ST_MCMP = 12'b1000_0000_0000
	} state_t;

	state_t st_q;
	state_t st_d;

	// configuration
	logic [3:0]    tcount_q;
	logic [NW-1:0] n_tests;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr == mta_pkg::ADDR_TEST_COUNT) ? {28'd0, tcount_q} : 32'd0;

	always_comb begin
		if (32'(tcount_q) > MAX_TEST_CASES) begin
			n_tests = NW'(MAX_TEST_CASES);
		end else begin
			n_tests = NW'(tcount_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcount_q <= mta_pkg::TEST_COUNT_RST;
		end else if (cfg_wr && paddr == mta_pkg::ADDR_TEST_COUNT) begin
			tcount_q <= pwdata[3:0];
		end
	end

	// latched item
	logic [2:0]    req_q;
	logic [3:0]    op_q;
	logic [RW-1:0] rd_q;
	logic [RW-1:0] rs_q;
	logic [RW-1:0] rt_q;
	logic [7:0]    imm_q;
	logic [TW-1:0] ti_q;
	logic          ok_q;

	// block state
	logic [DW-1:0]    exp_q [MAX_TEST_CASES];
	logic [FW-1:0]    flg_q [MAX_TEST_CASES];
	logic [7:0]       live_q;
	logic [7:0]       depth_q;
	logic [DEPTH-1:0] vld_q;

	// sequencer counters and ALU registers
	logic [TW-1:0] t_q;
	logic [RW-1:0] r_q;
	logic [7:0]    mm_q;
	logic [DW-1:0] a_q;
	logic [DW-1:0] b_q;
	logic [DW-1:0] res_q;
	logic [FW-1:0] rf_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] mb_q;
	logic [3:0]    cnt_q;
	logic [DW-1:0] rdv_q;
	logic [FW-1:0] rdf_q;

	logic last_t;
	assign last_t = (32'(t_q) + 1 == 32'(n_tests));

	// item decode at the input
	logic          in_xfer;
	logic          ti_ok;
	logic          rd_ok;
	logic [TW-1:0] ti_in;
	logic [RW-1:0] rd_in;
	logic          ex_ok;

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = (st_q != ST_IDLE);
	assign ti_ok    = (32'(test_index) < MAX_TEST_CASES);
	assign rd_ok    = (32'(dest_reg) < NUM_REGS);
	assign ti_in    = TW'(test_index);
	assign rd_in    = RW'(dest_reg);
	assign ex_ok    = (opcode <= mta_pkg::OP_ADDI) && rd_ok
	                  && (32'(src_a_reg) < NUM_REGS) && (32'(src_b_reg) < NUM_REGS);

	// register-file RAM
	logic          ram_we;
	logic [AW-1:0] ram_wa;
	logic [DW-1:0] ram_wd;
	logic [AW-1:0] ram_ra;
	logic [DW-1:0] ram_rd;
	logic          rvld_q;
	logic [DW-1:0] rdata;

	function automatic logic [AW-1:0] entry(input logic [TW-1:0] t, input logic [RW-1:0] r);
		entry = AW'(32'(t) * NUM_REGS + 32'(r));
	endfunction

	mta_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_regfile (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_wa),
		.wdata(ram_wd),
		.raddr(ram_ra),
		.rdata(ram_rd)
	);

	// never-written entries read as zero
	assign rdata = rvld_q ? ram_rd : '0;

	always_comb begin
		ram_ra = entry(ti_in, rd_in);
		unique case (st_q)
			ST_CHKR: ram_ra = entry(t_q, rt_q);
			ST_ARD:  ram_ra = entry(t_q, (op_q == mta_pkg::OP_ADDI) ? rd_q : rs_q);
			ST_BRD:  ram_ra = entry(t_q, rt_q);
			ST_MRD:  ram_ra = entry(t_q, r_q);
			// keep the compared entry on the read port while the output is blocked
			ST_MCMP: ram_ra = entry(t_q, r_q);
			default: ram_ra = entry(ti_in, rd_in);
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wa = entry(ti_in, rd_in);
		ram_wd = data_value;
		if (st_q == ST_IDLE) begin
			ram_we = in_xfer && req_type == mta_pkg::REQ_WRITE && ti_ok && rd_ok
			         && dest_reg != 3'd0;
		end else if (st_q == ST_WR) begin
			ram_we = (rd_q != '0);
			ram_wa = entry(t_q, rd_q);
			ram_wd = res_q;
		end
	end

	// shared ALU, one test per pass
	logic [DW-1:0] alu_b;
	logic [DW:0]   sum17;
	logic [DW:0]   dif17;
	logic [31:0]   prod;
	logic [DW-1:0] alu_res;
	logic [FW-1:0] alu_fl;
	logic [3:0]    sh;

	assign sh    = rdata[3:0];
	assign alu_b = (op_q == mta_pkg::OP_ADDI) ? {{8{imm_q[7]}}, imm_q} : rdata;
	assign sum17 = {1'b0, a_q} + {1'b0, alu_b};
	assign dif17 = {1'b0, a_q} - {1'b0, rdata};
	assign prod  = 32'(a_q) * 32'(rdata);

	always_comb begin
		alu_res = '0;
		alu_fl  = '0;
		case (op_q)
			mta_pkg::OP_ADD, mta_pkg::OP_ADDI: begin
				alu_res = sum17[DW-1:0];
				alu_fl[mta_pkg::FL_C] = sum17[DW];
				alu_fl[mta_pkg::FL_V] = ~(a_q[15] ^ alu_b[15]) & (a_q[15] ^ alu_res[15]);
			end
			mta_pkg::OP_SUB: begin
				alu_res = dif17[DW-1:0];
				alu_fl[mta_pkg::FL_C] = ~dif17[DW];
				alu_fl[mta_pkg::FL_V] = (a_q[15] ^ rdata[15]) & (a_q[15] ^ alu_res[15]);
			end
			mta_pkg::OP_MUL: begin
				alu_res = prod[DW-1:0];
				alu_fl[mta_pkg::FL_C] = |prod[31:16];
			end
			mta_pkg::OP_AND: alu_res = a_q & rdata;
			mta_pkg::OP_OR:  alu_res = a_q | rdata;
			mta_pkg::OP_XOR: alu_res = a_q ^ rdata;
			mta_pkg::OP_SHL: alu_res = a_q << sh;
			mta_pkg::OP_SHR: alu_res = a_q >> sh;
			mta_pkg::OP_ASR: alu_res = DW'($signed(a_q) >>> sh);
			mta_pkg::OP_LDI: alu_res = {8'd0, imm_q};
			default: alu_res = '0;
		endcase
		alu_fl[mta_pkg::FL_Z] = (alu_res == '0);
		alu_fl[mta_pkg::FL_N] = alu_res[15];
	end

	// restoring divider on magnitudes, one quotient bit per cycle
	logic [DW+1:0] trial;
	logic [DW-1:0] q_sgn;
	logic [DW-1:0] r_sgn;
	logic [DW-1:0] d_res;

	assign trial = {1'b0, rem_q, quo_q[15]} - {2'b00, mb_q};
	assign q_sgn = (a_q[15] ^ b_q[15]) ? (~quo_q + 16'd1) : quo_q;
	assign r_sgn = a_q[15] ? (~rem_q + 16'd1) : rem_q;
	assign d_res = (op_q == mta_pkg::OP_DIV) ? q_sgn : r_sgn;

	// sequencer
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (req_type == mta_pkg::REQ_READ && ti_ok && rd_ok) begin
						st_d = ST_RDW;
					end else if (req_type == mta_pkg::REQ_EXEC && ex_ok && n_tests != '0) begin
						if (opcode == mta_pkg::OP_DIV || opcode == mta_pkg::OP_MOD) begin
							st_d = ST_CHKR;
						end else begin
							st_d = ST_ARD;
						end
					end else begin
						st_d = ST_MRD;
					end
				end
			end
			ST_CHKR: st_d = ST_CHKW;
			ST_CHKW: begin
				if (rdata == '0) begin
					st_d = ST_MRD;
				end else if (last_t) begin
					st_d = ST_ARD;
				end else begin
					st_d = ST_CHKR;
				end
			end
			ST_ARD:  st_d = ST_BRD;
			ST_BRD:  st_d = ST_EXEC;
			ST_EXEC: begin
				if (op_q == mta_pkg::OP_DIV || op_q == mta_pkg::OP_MOD) begin
					st_d = ST_DIV;
				end else begin
					st_d = ST_WR;
				end
			end
			ST_DIV:  st_d = (cnt_q == 4'd15) ? ST_DFIN : ST_DIV;
			ST_DFIN: st_d = ST_WR;
			ST_WR:   st_d = last_t ? ST_MRD : ST_ARD;
			ST_RDW:  st_d = ST_MRD;
			ST_MRD:  st_d = ST_MCMP;
			ST_MCMP: begin
				if ((n_tests == '0 || last_t) && 32'(r_q) == NUM_REGS - 1) begin
					if (!out_valid || !out_stall) begin
						st_d = ST_IDLE;
					end
				end else begin
					st_d = ST_MRD;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			live_q  <= '0;
			depth_q <= '0;
			vld_q   <= '0;
			rvld_q  <= 1'b0;
			ok_q    <= 1'b0;
			t_q     <= '0;
			r_q     <= '0;
			for (int i = 0; i < MAX_TEST_CASES; i++) begin
				exp_q[i] <= '0;
				flg_q[i] <= '0;
			end
		end else begin
			st_q   <= st_d;
			rvld_q <= vld_q[ram_ra];
			if (ram_we) begin
				vld_q[ram_wa] <= 1'b1;
			end
			unique case (st_q)
				ST_IDLE: begin
					t_q <= '0;
					r_q <= RW'(1);
					if (in_xfer) begin
						ok_q <= 1'b0;
						unique case (req_type)
							mta_pkg::REQ_CLEAR: begin
								vld_q   <= '0;
								live_q  <= '0;
								depth_q <= '0;
								ok_q    <= 1'b1;
								for (int i = 0; i < MAX_TEST_CASES; i++) begin
									flg_q[i] <= '0;
								end
							end
							mta_pkg::REQ_WRITE: begin
								if (ti_ok && rd_ok && dest_reg != 3'd0) begin
									live_q[dest_reg] <= 1'b1;
									ok_q <= 1'b1;
								end
							end
							mta_pkg::REQ_EXPECT: begin
								if (ti_ok) begin
									exp_q[ti_in] <= data_value;
									ok_q <= 1'b1;
								end
							end
							mta_pkg::REQ_EXEC: begin
								// no test in use: commits with nothing to compute
								if (ex_ok && n_tests == '0) begin
									ok_q    <= 1'b1;
									depth_q <= depth_q + 8'd1;
									if (dest_reg != 3'd0) begin
										live_q[dest_reg] <= 1'b1;
									end
								end
							end
							mta_pkg::REQ_READ: ok_q <= ti_ok && rd_ok;
							default: ok_q <= 1'b0;
						endcase
					end
				end
				ST_CHKW: begin
					if (rdata == '0) begin
						t_q <= '0;
					end else begin
						t_q <= last_t ? '0 : t_q + TW'(1);
					end
				end
				ST_WR: begin
					if (op_q != mta_pkg::OP_LDI) begin
						flg_q[t_q] <= rf_q;
					end
					if (last_t) begin
						t_q     <= '0;
						ok_q    <= 1'b1;
						depth_q <= depth_q + 8'd1;
						if (rd_q != '0) begin
							live_q[rd_q] <= 1'b1;
						end
					end else begin
						t_q <= t_q + TW'(1);
					end
				end
				ST_MCMP: begin
					// hold the sweep position while the last compare waits
					if (st_d != ST_MCMP) begin
						if (n_tests == '0 || last_t) begin
							t_q <= '0;
							r_q <= r_q + RW'(1);
						end else begin
							t_q <= t_q + TW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_xfer) begin
			req_q <= req_type;
			op_q  <= opcode;
			rd_q  <= rd_in;
			rs_q  <= RW'(src_a_reg);
			rt_q  <= RW'(src_b_reg);
			imm_q <= immediate;
			ti_q  <= ti_in;
		end
		if (st_q == ST_BRD) begin
			a_q <= rdata;
		end
		if (st_q == ST_EXEC) begin
			b_q   <= rdata;
			res_q <= alu_res;
			rf_q  <= alu_fl;
			quo_q <= a_q[15] ? (~a_q + 16'd1) : a_q;
			mb_q  <= rdata[15] ? (~rdata + 16'd1) : rdata;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (st_q == ST_DIV) begin
			cnt_q <= cnt_q + 4'd1;
			if (!trial[DW+1]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], quo_q[15]};
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
		if (st_q == ST_DFIN) begin
			res_q <= d_res;
			rf_q  <= {2'b00, d_res[15], d_res == '0};
		end
		if (st_q == ST_RDW) begin
			rdv_q <= rdata;
			rdf_q <= flg_q[ti_q];
		end
		// match sweep: start from the live set, drop a register on any mismatch
		if (st_q == ST_IDLE) begin
			mm_q <= '0;
		end
		if (st_q == ST_MRD && r_q == RW'(1) && t_q == '0) begin
			mm_q <= live_q & 8'hFE;
		end
		if (st_q == ST_MCMP && n_tests != '0 && rdata != exp_q[t_q]) begin
			mm_q[r_q] <= 1'b0;
		end
	end

	// output register; the last compare folds straight into match_mask
	logic       out_load;
	logic [7:0] mm_fin;

	assign out_load = (st_q == ST_MCMP) && (st_d == ST_IDLE);

	always_comb begin
		mm_fin = mm_q;
		if (n_tests != '0 && rdata != exp_q[t_q]) begin
			mm_fin[r_q] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			accepted   <= ok_q;
			match_mask <= mm_fin;
			live_mask  <= live_q;
			depth_now  <= depth_q;
			read_value <= (ok_q && req_q == mta_pkg::REQ_READ) ? rdv_q : '0;
			read_flags <= (ok_q && req_q == mta_pkg::REQ_READ) ? rdf_q : '0;
		end
	end

endmodule
